[rtl/adsr_pkg.sv]
// Shared types and constants for the ADSR envelope generator.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

  // Envelope phases
  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SHAPE_ENABLED = 3'd0,
    REG_ATTACK_TICKS  = 3'd1,
    REG_DECAY_TICKS   = 3'd2,
    REG_SUSTAIN_LEVEL = 3'd3,
    REG_RELEASE_TICKS = 3'd4
  } cfg_reg_t;

  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // ticks * 1024 spans 26 bits; the period after /255 fits in 19 bits
  localparam int unsigned SCALED_W = TICKS_W + 10;
  localparam int unsigned PERIOD_W = 19;

  // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for every x below 2^26
  localparam int unsigned RECIP_SHIFT = 34;
  localparam int unsigned RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_255 = 27'd67372037;

  localparam logic [ACC_W-1:0]   TICK_INC    = 32'd1024;
  localparam logic [ACC_W-1:0]   HOLD_PERIOD = 32'h8000_0000;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 8'd255;
  localparam logic [LEVEL_W-1:0] ATTACK_TOP  = 8'd254;

  // One result transaction
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_t             phase_now;
    logic               finished;
  } result_t;

  // Phase time in ticks to timer period: (ticks * 1024) / 255
  function automatic logic [PERIOD_W-1:0] ticks_to_period(input logic [TICKS_W-1:0] ticks);
    logic [SCALED_W-1:0]         scaled;
    logic [SCALED_W+RECIP_W-1:0] prod;
    scaled = {ticks, 10'b0};
    prod   = {{RECIP_W{1'b0}}, scaled} * {{SCALED_W{1'b0}}, RECIP_255};
    return prod[RECIP_SHIFT +: PERIOD_W];
  endfunction

endpackage

`default_nettype wire

[rtl/adsr_envelope_generator.sv]
// ADSR envelope generator top level: envelope state, timer and output buffering.
//
// Usage: each input transaction on in_* is either a sample tick (in_op = 0) or a
// jump to the phase in in_target_phase (in_op = 1). Every accepted transaction
// yields exactly one result on out_*: the envelope level, the phase and the
// finished flag, all taken after the transaction has been applied.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must write
// them only while the block is idle, which the block itself does not enforce. Phase
// times are converted to timer periods (ticks * 1024 / 255) when written, using one constant multiplier.
// Output: each result is registered on out_* directly, or via the skid register.
// Throughput: one transaction per cycle while in_ready is high; the state update is a
// single pass of add, compare and select between the state registers.
// Stalls: a two-entry output (result register plus skid register) lets one
// more transaction in while a result waits; in_ready drops only once both
// entries are full, and results leave in order.
// Reset (rst_n low, synchronous): registers and envelope state clear to zero,
// phase attack, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_generator (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_op,
  input  wire logic [1:0]                            in_target_phase,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [adsr_pkg::LEVEL_W-1:0]               out_level,
  output logic [1:0]                                 out_phase_now,
  output logic                                       out_finished,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic [adsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // configuration registers (periods stored already converted)
  logic                              en_r;
  logic [adsr_pkg::PERIOD_W-1:0]     attack_p_r;
  logic [adsr_pkg::PERIOD_W-1:0]     decay_p_r;
  logic [adsr_pkg::LEVEL_W-1:0]      sustain_r;
  logic [adsr_pkg::PERIOD_W-1:0]     release_p_r;
  logic [adsr_pkg::PERIOD_W-1:0]     cfg_period;

  // envelope state
  adsr_pkg::phase_t                  phase_r, phase_nxt;
  logic [adsr_pkg::LEVEL_W-1:0]      amp_r, amp_nxt;
  logic                              done_r, done_nxt;
  logic [adsr_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [adsr_pkg::ACC_W-1:0]        period_r, period_nxt;

  // output buffer
  logic                              out_valid_r;
  logic                              skid_valid_r;
  adsr_pkg::result_t                 out_data_r;
  adsr_pkg::result_t                 skid_data_r;
  adsr_pkg::result_t                 result;

  logic                              in_fire;
  logic                              jump;
  adsr_pkg::phase_t                  jump_tgt;
  logic [adsr_pkg::LEVEL_W-1:0]      amp_base;
  logic [adsr_pkg::ACC_W-1:0]        acc_sum;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  // ---- configuration writes ----
  assign cfg_period = adsr_pkg::ticks_to_period(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      attack_p_r  <= '0;
      decay_p_r   <= '0;
      sustain_r   <= '0;
      release_p_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adsr_pkg::REG_SHAPE_ENABLED: en_r        <= cfg_wdata[0];
        adsr_pkg::REG_ATTACK_TICKS:  attack_p_r  <= cfg_period;
        adsr_pkg::REG_DECAY_TICKS:   decay_p_r   <= cfg_period;
        adsr_pkg::REG_SUSTAIN_LEVEL: sustain_r   <= cfg_wdata[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::REG_RELEASE_TICKS: release_p_r <= cfg_period;
        default: ; // unmapped index, ignored
      endcase
    end
  end

  // ---- envelope next state ----
  always_comb begin
    phase_nxt  = phase_r;
    amp_nxt    = amp_r;
    done_nxt   = done_r;
    acc_nxt    = acc_r;
    period_nxt = period_r;
    jump       = 1'b0;
    jump_tgt   = phase_r;
    amp_base   = amp_r;
    acc_sum    = acc_r + adsr_pkg::TICK_INC;

    if (en_r) begin
      if (in_op) begin
        jump     = 1'b1;
        jump_tgt = adsr_pkg::phase_t'(in_target_phase);
      end else if (!done_r) begin
        acc_nxt = acc_sum;
        // timer fires: subtract period and take one level step (none in sustain)
        if (acc_sum >= period_r) begin
          acc_nxt = acc_sum - period_r;
          unique case (phase_r)
            adsr_pkg::PH_ATTACK: begin
              if (amp_r >= adsr_pkg::ATTACK_TOP) begin
                jump     = 1'b1;
                jump_tgt = adsr_pkg::PH_DECAY;
              end else begin
                amp_nxt = amp_r + 8'd1;
              end
            end
            adsr_pkg::PH_DECAY: begin
              // amp - 1 <= sustain, with amp == 0 counting as below
              if ({1'b0, amp_r} <= ({1'b0, sustain_r} + 9'd1)) begin
                jump     = 1'b1;
                jump_tgt = adsr_pkg::PH_SUSTAIN;
              end else begin
                amp_nxt = amp_r - 8'd1;
              end
            end
            adsr_pkg::PH_SUSTAIN: ;
            adsr_pkg::PH_RELEASE: begin
              if (amp_r <= 8'd1) begin
                done_nxt = 1'b1;
              end else begin
                amp_nxt = amp_r - 8'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end

    // phase entry: level start, period reload, accumulator clear (bar an ended release)
    if (jump) begin
      phase_nxt = jump_tgt;
      amp_base  = done_r ? '0 : amp_r;
      amp_nxt   = amp_base;
      done_nxt  = 1'b0;
      unique case (jump_tgt)
        adsr_pkg::PH_ATTACK: begin
          period_nxt = {{(adsr_pkg::ACC_W-adsr_pkg::PERIOD_W){1'b0}}, attack_p_r};
          acc_nxt    = '0;
        end
        adsr_pkg::PH_DECAY: begin
          amp_nxt    = adsr_pkg::FULL_LEVEL;
          period_nxt = {{(adsr_pkg::ACC_W-adsr_pkg::PERIOD_W){1'b0}}, decay_p_r};
          acc_nxt    = '0;
        end
        adsr_pkg::PH_SUSTAIN: begin
          amp_nxt    = sustain_r;
          period_nxt = adsr_pkg::HOLD_PERIOD;
          acc_nxt    = '0;
        end
        adsr_pkg::PH_RELEASE: begin
          // an ended release stays silent with its timer untouched
          if (!done_r) begin
            amp_nxt    = sustain_r;
            period_nxt = {{(adsr_pkg::ACC_W-adsr_pkg::PERIOD_W){1'b0}}, release_p_r};
            acc_nxt    = '0;
          end
        end
        default: ;
      endcase
    end

    result.level     = !en_r ? adsr_pkg::FULL_LEVEL : (done_nxt ? '0 : amp_nxt);
    result.phase_now = phase_nxt;
    result.finished  = done_nxt;
  end

  // ---- envelope state registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= adsr_pkg::PH_ATTACK;
      amp_r    <= '0;
      done_r   <= 1'b0;
      acc_r    <= '0;
      period_r <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      amp_r    <= amp_nxt;
      done_r   <= done_nxt;
      acc_r    <= acc_nxt;
      period_r <= period_nxt;
    end
  end

  // ---- output register with skid entry ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= result;
      end
    end else if (in_fire) begin
      skid_data_r <= result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_data_r.level;
  assign out_phase_now = out_data_r.phase_now;
  assign out_finished  = out_data_r.finished;

  // ---- assertions ----
  // the skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // the envelope can only have ended in release
  a_done_in_release: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (phase_r == adsr_pkg::PH_RELEASE))
    else $error("finished flag set outside release");

  // a delivered finished result always reports release
  a_out_finished_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.finished) |-> (out_data_r.phase_now == adsr_pkg::PH_RELEASE))
    else $error("finished result not in release phase");

  // ticks after the end leave the timer frozen
  a_done_timer_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && in_fire && !in_op) |=> ($stable(acc_r) && $stable(period_r)))
    else $error("timer moved after envelope ended");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for adsr_envelope_generator: directed table, random envelopes.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ITEM_BUDGET   = 1850;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned GAP_FREE_FROM = 900;
  localparam int unsigned GAP_FREE_LEN  = 300;
  localparam logic [31:0] TICK_STEP     = 32'd1024;
  localparam logic [31:0] HOLD_STEP     = 32'h8000_0000;
  localparam logic [7:0]  LEVEL_TOP     = 8'd255;
  localparam logic        OP_TICK       = 1'b0;
  localparam logic        OP_JUMP       = 1'b1;

  // One row of the directed table: a register write or a transaction
  typedef struct packed {
    logic                 is_cfg;
    adsr_pkg::cfg_reg_t   reg_idx;
    logic [15:0]          reg_val;
    logic                 op;
    adsr_pkg::phase_t     target;
    logic                 typed;
    adsr_pkg::result_t    want;
  } plan_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_op;
  logic [1:0]                      in_target_phase;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [adsr_pkg::LEVEL_W-1:0]    out_level;
  logic [1:0]                      out_phase_now;
  logic                            out_finished;
  logic                            cfg_we;
  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Envelope predictor: register copies and state
  logic              shape_on;
  logic [15:0]       attack_len;
  logic [15:0]       decay_len;
  logic [15:0]       release_len;
  logic [7:0]        sustain_lvl;
  adsr_pkg::phase_t  env_phase;
  logic [7:0]        env_amp;
  logic              env_done;
  logic [31:0]       env_acc;
  logic [31:0]       env_period;

  adsr_pkg::result_t envelope_due[$];
  plan_row_t         plan[$];
  logic              no_gaps = 1'b0;
  logic              random_part = 1'b0;

  int unsigned items_sent = 0;
  int unsigned directed_items = 0;
  int unsigned jumps_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned results_seen = 0;
  int unsigned silent_results = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  adsr_envelope_generator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_target_phase (in_target_phase),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_level       (out_level),
    .out_phase_now   (out_phase_now),
    .out_finished    (out_finished),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Phase time in ticks to timer period
  function automatic logic [31:0] ticks_period(input logic [15:0] ticks);
    return ({16'b0, ticks} * TICK_STEP) / 32'd255;
  endfunction

  function automatic void enter_phase(input adsr_pkg::phase_t tgt);
    env_phase = tgt;
    if (env_done) env_amp = 8'd0;
    case (tgt)
      adsr_pkg::PH_ATTACK: begin
        env_period = ticks_period(attack_len);
        env_acc    = 32'd0;
      end
      adsr_pkg::PH_DECAY: begin
        env_amp    = LEVEL_TOP;
        env_period = ticks_period(decay_len);
        env_acc    = 32'd0;
      end
      adsr_pkg::PH_SUSTAIN: begin
        env_amp    = sustain_lvl;
        env_period = HOLD_STEP;
        env_acc    = 32'd0;
      end
      default: begin
        // a finished release keeps its timer and stays silent
        if (!env_done) begin
          env_amp    = sustain_lvl;
          env_period = ticks_period(release_len);
          env_acc    = 32'd0;
        end
      end
    endcase
    env_done = 1'b0;
  endfunction

  // One level step when the timer fires
  function automatic void take_step();
    case (env_phase)
      adsr_pkg::PH_ATTACK: begin
        if (int'(env_amp) + 1 >= int'(LEVEL_TOP)) enter_phase(adsr_pkg::PH_DECAY);
        else env_amp = env_amp + 8'd1;
      end
      adsr_pkg::PH_DECAY: begin
        if (int'(env_amp) - 1 <= int'(sustain_lvl)) enter_phase(adsr_pkg::PH_SUSTAIN);
        else env_amp = env_amp - 8'd1;
      end
      adsr_pkg::PH_RELEASE: begin
        if (env_amp <= 8'd1) env_done = 1'b1;
        else env_amp = env_amp - 8'd1;
      end
      default: ;
    endcase
  endfunction

  // Apply one transaction to the predictor and return the result it yields
  function automatic adsr_pkg::result_t advance_envelope(input logic op,
                                                         input adsr_pkg::phase_t tgt);
    adsr_pkg::result_t r;
    if (shape_on) begin
      if (op == OP_JUMP) begin
        enter_phase(tgt);
      end else if (!env_done) begin
        env_acc = env_acc + TICK_STEP;
        if (env_acc >= env_period) begin
          env_acc = env_acc - env_period;
          take_step();
        end
      end
    end
    r.level     = !shape_on ? LEVEL_TOP : (env_done ? 8'd0 : env_amp);
    r.phase_now = env_phase;
    r.finished  = env_done;
    return r;
  endfunction

  // Table builders
  function automatic void add_step(input logic op, input adsr_pkg::phase_t tgt);
    plan_row_t row;
    row        = '0;
    row.op     = op;
    row.target = tgt;
    plan.push_back(row);
  endfunction

  function automatic void add_check(input logic op, input adsr_pkg::phase_t tgt,
                                    input logic [7:0] lvl, input adsr_pkg::phase_t ph,
                                    input logic fin);
    plan_row_t row;
    row                = '0;
    row.op             = op;
    row.target         = tgt;
    row.typed          = 1'b1;
    row.want.level     = lvl;
    row.want.phase_now = ph;
    row.want.finished  = fin;
    plan.push_back(row);
  endfunction

  function automatic void add_reg(input adsr_pkg::cfg_reg_t idx, input logic [15:0] val);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  // Drive one transaction; called and returns at a falling edge
  task automatic send_item(input logic op, input adsr_pkg::phase_t tgt, input logic typed,
                           input adsr_pkg::result_t want);
    adsr_pkg::result_t r;
    // gap-free stretch counted in transactions of the random part
    if (random_part) begin
      no_gaps = (items_sent >= directed_items + GAP_FREE_FROM) &&
                (items_sent < directed_items + GAP_FREE_FROM + GAP_FREE_LEN);
    end
    if (!no_gaps) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_target_phase <= tgt;
    do @(posedge clk); while (!in_ready);
    r = advance_envelope(op, tgt);
    envelope_due.push_back(typed ? want : r);
    items_sent++;
    if (op == OP_JUMP) jumps_sent++;
    @(negedge clk);
  endtask

  task automatic tick();
    send_item(OP_TICK, adsr_pkg::phase_t'($urandom_range(3)), 1'b0, '0);
  endtask

  task automatic jump(input adsr_pkg::phase_t tgt);
    send_item(OP_JUMP, tgt, 1'b0, '0);
  endtask

  // Hold off the sender until every result is back and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (envelope_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write; the caller drops cfg_we after the last one
  task automatic apply_reg(input adsr_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      adsr_pkg::REG_SHAPE_ENABLED: shape_on    = val[0];
      adsr_pkg::REG_ATTACK_TICKS:  attack_len  = val;
      adsr_pkg::REG_DECAY_TICKS:   decay_len   = val;
      adsr_pkg::REG_SUSTAIN_LEVEL: sustain_lvl = val[7:0];
      adsr_pkg::REG_RELEASE_TICKS: release_len = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Mostly short phase times so envelopes run through; some at the extremes
  function automatic logic [15:0] pick_ticks();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 65) return 16'($urandom_range(600));
    else if (sel < 80) return 16'($urandom_range(4000, 601));
    else if (sel < 88) return 16'hFFFF;
    else if (sel < 93) return 16'd0;
    else return 16'($urandom);
  endfunction

  task automatic reprogram();
    int unsigned sel;
    logic [7:0]  lvl;
    sel = $urandom_range(99);
    lvl = (sel < 10) ? 8'd0 : (sel < 20) ? LEVEL_TOP : 8'($urandom);
    drain_results();
    apply_reg(adsr_pkg::REG_SHAPE_ENABLED, 16'($urandom_range(99) >= 8));
    apply_reg(adsr_pkg::REG_ATTACK_TICKS, pick_ticks());
    apply_reg(adsr_pkg::REG_DECAY_TICKS, pick_ticks());
    apply_reg(adsr_pkg::REG_SUSTAIN_LEVEL, {8'b0, lvl});
    apply_reg(adsr_pkg::REG_RELEASE_TICKS, pick_ticks());
    cfg_we <= 1'b0;
  endtask

  // Note on, optional decay/sustain jumps, note off, release ticks, optional last jump
  task automatic envelope_run();
    int unsigned n;
    jump(adsr_pkg::PH_ATTACK);
    n = $urandom_range(300);
    repeat (n) tick();
    if ($urandom_range(99) < 30) begin
      jump(adsr_pkg::PH_DECAY);
      n = $urandom_range(200);
      repeat (n) tick();
    end
    if ($urandom_range(99) < 15) begin
      jump(adsr_pkg::PH_SUSTAIN);
      n = $urandom_range(20);
      repeat (n) tick();
    end
    jump(adsr_pkg::PH_RELEASE);
    n = $urandom_range(320);
    repeat (n) tick();
    if ($urandom_range(99) < 25) begin
      jump(adsr_pkg::phase_t'($urandom_range(3)));
      n = $urandom_range(10);
      repeat (n) tick();
    end
  endtask

  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(30, 5);
    repeat (n) send_item(1'($urandom_range(1)), adsr_pkg::phase_t'($urandom_range(3)),
                         1'b0, '0);
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 25);
  end

  // Result checker
  always @(posedge clk) begin : check_results
    adsr_pkg::result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (envelope_due.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none, got level %0d phase %0d fin %0b",
                 $time, out_level, out_phase_now, out_finished);
        error_count++;
      end else begin
        due = envelope_due.pop_front();
        if (out_level !== due.level) begin
          $display("%0t ns: level mismatch, expected %0d, got %0d", $time, due.level, out_level);
          error_count++;
        end
        if (out_phase_now !== due.phase_now) begin
          $display("%0t ns: phase mismatch, expected %0d, got %0d",
                   $time, due.phase_now, out_phase_now);
          error_count++;
        end
        if (out_finished !== due.finished) begin
          $display("%0t ns: finished mismatch, expected %0b, got %0b",
                   $time, due.finished, out_finished);
          error_count++;
        end
        results_seen++;
        if (out_finished === 1'b1) silent_results++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timed out after %0d cycles", $time, cycle_count);
      $display("adsr_envelope_generator verification failed");
      $finish;
    end
  end

  initial begin
    in_valid        = 1'b0;
    in_op           = 1'b0;
    in_target_phase = 2'd0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    shape_on        = 1'b0;
    attack_len      = 16'd0;
    decay_len       = 16'd0;
    release_len     = 16'd0;
    sustain_lvl     = 8'd0;
    env_phase       = adsr_pkg::PH_ATTACK;
    env_amp         = 8'd0;
    env_done        = 1'b0;
    env_acc         = 32'd0;
    env_period      = 32'd0;

    // Disabled after reset, then short phases with a low sustain
    add_check(OP_TICK, adsr_pkg::PH_ATTACK, LEVEL_TOP, adsr_pkg::PH_ATTACK, 1'b0);
    add_check(OP_JUMP, adsr_pkg::PH_DECAY, LEVEL_TOP, adsr_pkg::PH_ATTACK, 1'b0);
    add_reg(adsr_pkg::REG_SHAPE_ENABLED, 16'd1);
    add_reg(adsr_pkg::REG_SUSTAIN_LEVEL, 16'd2);
    add_reg(adsr_pkg::REG_ATTACK_TICKS, 16'd0);
    add_reg(adsr_pkg::REG_DECAY_TICKS, 16'd0);
    add_reg(adsr_pkg::REG_RELEASE_TICKS, 16'd0);
    add_step(OP_TICK, adsr_pkg::PH_ATTACK);
    add_check(OP_JUMP, adsr_pkg::PH_DECAY, LEVEL_TOP, adsr_pkg::PH_DECAY, 1'b0);
    add_step(OP_TICK, adsr_pkg::PH_SUSTAIN);
    add_check(OP_JUMP, adsr_pkg::PH_SUSTAIN, 8'd2, adsr_pkg::PH_SUSTAIN, 1'b0);
    add_step(OP_TICK, adsr_pkg::PH_RELEASE);
    add_check(OP_JUMP, adsr_pkg::PH_RELEASE, 8'd2, adsr_pkg::PH_RELEASE, 1'b0);
    add_step(OP_TICK, adsr_pkg::PH_DECAY);
    // release ends, stays silent, restarts from silence
    add_check(OP_TICK, adsr_pkg::PH_ATTACK, 8'd0, adsr_pkg::PH_RELEASE, 1'b1);
    add_check(OP_TICK, adsr_pkg::PH_RELEASE, 8'd0, adsr_pkg::PH_RELEASE, 1'b1);
    add_check(OP_JUMP, adsr_pkg::PH_RELEASE, 8'd0, adsr_pkg::PH_RELEASE, 1'b0);
    add_check(OP_TICK, adsr_pkg::PH_SUSTAIN, 8'd0, adsr_pkg::PH_RELEASE, 1'b1);
    add_check(OP_JUMP, adsr_pkg::PH_ATTACK, 8'd0, adsr_pkg::PH_ATTACK, 1'b0);
    add_step(OP_TICK, adsr_pkg::PH_DECAY);
    add_step(OP_JUMP, adsr_pkg::PH_ATTACK);
    // longest phase times, full sustain
    add_reg(adsr_pkg::REG_ATTACK_TICKS, 16'hFFFF);
    add_reg(adsr_pkg::REG_DECAY_TICKS, 16'hFFFF);
    add_reg(adsr_pkg::REG_RELEASE_TICKS, 16'hFFFF);
    add_reg(adsr_pkg::REG_SUSTAIN_LEVEL, 16'd255);
    add_check(OP_JUMP, adsr_pkg::PH_DECAY, LEVEL_TOP, adsr_pkg::PH_DECAY, 1'b0);
    add_step(OP_TICK, adsr_pkg::PH_ATTACK);
    add_check(OP_JUMP, adsr_pkg::PH_SUSTAIN, LEVEL_TOP, adsr_pkg::PH_SUSTAIN, 1'b0);
    add_check(OP_JUMP, adsr_pkg::PH_RELEASE, LEVEL_TOP, adsr_pkg::PH_RELEASE, 1'b0);
    add_step(OP_TICK, adsr_pkg::PH_RELEASE);
    // disabled: state held, level at full scale
    add_reg(adsr_pkg::REG_SHAPE_ENABLED, 16'd0);
    add_check(OP_TICK, adsr_pkg::PH_SUSTAIN, LEVEL_TOP, adsr_pkg::PH_RELEASE, 1'b0);
    add_check(OP_JUMP, adsr_pkg::PH_ATTACK, LEVEL_TOP, adsr_pkg::PH_RELEASE, 1'b0);
    // attack entered at the top level falls straight into decay
    add_reg(adsr_pkg::REG_SHAPE_ENABLED, 16'd1);
    add_reg(adsr_pkg::REG_SUSTAIN_LEVEL, 16'd0);
    add_reg(adsr_pkg::REG_ATTACK_TICKS, 16'd255);
    add_reg(adsr_pkg::REG_DECAY_TICKS, 16'd1);
    add_check(OP_JUMP, adsr_pkg::PH_ATTACK, LEVEL_TOP, adsr_pkg::PH_ATTACK, 1'b0);
    add_step(OP_TICK, adsr_pkg::PH_ATTACK);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) drain_results();
        apply_reg(plan[i].reg_idx, plan[i].reg_val);
        if (i + 1 == plan.size() || !plan[i+1].is_cfg) cfg_we <= 1'b0;
      end else begin
        send_item(plan[i].op, plan[i].target, plan[i].typed, plan[i].want);
      end
    end
    directed_items = items_sent;

    // Random envelopes with occasional reprogramming and noise
    random_part = 1'b1;
    while (items_sent < directed_items + ITEM_BUDGET) begin
      if ($urandom_range(99) < 55) reprogram();
      if ($urandom_range(99) < 85) envelope_run();
      else noise_burst();
    end
    random_part = 1'b0;
    no_gaps = 1'b0;

    drain_results();
    $display("Covered %0d transactions (%0d directed), %0d phase jumps, %0d register writes.",
             items_sent, directed_items, jumps_sent, reg_writes);
    $display("Checked %0d results, %0d of them with the envelope finished.",
             results_seen, silent_results);
    if (error_count == 0) begin
      $display("adsr_envelope_generator verification clean");
    end else begin
      $display("adsr_envelope_generator verification failed");
    end
    $finish;
  end

endmodule
